[rtl/assert_macros.svh]
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MMA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("moving average check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MMA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("moving average check failed");

`endif

[rtl/mma_pkg.sv]
// Package for the moving average core: widths, defaults and control structs.
`timescale 1ns / 1ps
package mma_pkg;

    localparam int CHANNELS_DEF        = 4;
    localparam int MAX_WINDOW_LOG2_DEF = 6;

    localparam int CHAN_W   = 2;
    localparam int SAMPLE_W = 16;
    localparam int WIN_W    = 3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear_step;   // write zero at the clearing pointer and advance it
        logic load;         // capture the input transaction
        logic write;        // store the sample and advance the write position
        logic clr_acc;      // zero the accumulator and the read index
        logic rd_issue;     // read the next window entry
        logic out_load;     // load the output register
    } mma_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clear_last;   // clearing pointer is at the last entry
        logic rd_last;      // read index is at the last window entry
        logic bypass;       // captured transaction passes straight through
    } mma_status_t;

endpackage

[rtl/mma_datapath.sv]
// Datapath: sample memory, write positions, accumulator and output register.
`timescale 1ns / 1ps
module mma_datapath #(
    parameter int CHANNELS        = mma_pkg::CHANNELS_DEF,
    parameter int MAX_WINDOW_LOG2 = mma_pkg::MAX_WINDOW_LOG2_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mma_pkg::CHAN_W-1:0]    channel,
    input  logic [mma_pkg::SAMPLE_W-1:0]  sample,
    input  logic [mma_pkg::WIN_W-1:0]     window_log2,
    input  mma_pkg::mma_cmd_t             cmd,
    output mma_pkg::mma_status_t          status,
    output logic [mma_pkg::SAMPLE_W-1:0]  average
);
    import mma_pkg::*;

    localparam int DEPTH     = 1 << MAX_WINDOW_LOG2;
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ADDR_W    = CH_W + MAX_WINDOW_LOG2;
    localparam int MEM_DEPTH = CHANNELS * DEPTH;
    localparam int SZ_W      = $clog2(MAX_WINDOW_LOG2 + 1);
    localparam int LEN_W     = MAX_WINDOW_LOG2 + 1;
    localparam int SUM_W     = SAMPLE_W + MAX_WINDOW_LOG2;

    // Captured transaction
    logic [CHAN_W-1:0]   ch_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SZ_W-1:0]     size_reg;
    logic                bypass_reg;
    logic [SZ_W-1:0]     size_next;
    logic                bypass_next;

    // Sample memory and per-channel write positions
    logic [SAMPLE_W-1:0]        mem [MEM_DEPTH];
    logic [MAX_WINDOW_LOG2-1:0] wpos_reg [CHANNELS];
    logic [ADDR_W-1:0]          clr_cnt_reg;
    logic [MAX_WINDOW_LOG2-1:0] rd_idx_reg;
    logic [SAMPLE_W-1:0]        rd_data_reg;
    logic                       acc_en_reg;
    logic [SUM_W-1:0]           acc_reg;
    logic [SAMPLE_W-1:0]        average_reg;

    logic [CH_W-1:0]            ch_idx;
    logic [LEN_W-1:0]           win_len;
    logic [LEN_W-1:0]           win_last;
    logic [MAX_WINDOW_LOG2-1:0] pos_cur;
    logic [LEN_W-1:0]           pos_inc;
    logic [MAX_WINDOW_LOG2-1:0] pos_wrap;
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_wa;
    logic [SAMPLE_W-1:0]        mem_wd;
    logic [ADDR_W-1:0]          rd_addr;
    logic [SUM_W-1:0]           shifted;
    logic [SAMPLE_W-1:0]        result_val;

    // Window size saturation and bypass decode on the incoming transaction
    always_comb
    begin
        if (32'(window_log2) > MAX_WINDOW_LOG2)
        begin
            size_next = SZ_W'(MAX_WINDOW_LOG2);
        end
        else
        begin
            size_next = SZ_W'(window_log2);
        end
        bypass_next = (window_log2 == '0) || (32'(channel) >= CHANNELS);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ch_reg     <= channel;
            sample_reg <= sample;
            size_reg   <= size_next;
            bypass_reg <= bypass_next;
        end
    end

    // Window length and the wrapped next write position
    assign ch_idx   = CH_W'(ch_reg);
    assign win_len  = LEN_W'(1) << size_reg;
    assign win_last = win_len - LEN_W'(1);
    assign pos_cur  = wpos_reg[ch_idx];
    assign pos_inc  = {1'b0, pos_cur} + LEN_W'(1);
    assign pos_wrap = (pos_inc >= win_len) ? '0 : pos_inc[MAX_WINDOW_LOG2-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                wpos_reg[i] <= '0;
            end
        end
        else if (cmd.write)
        begin
            wpos_reg[ch_idx] <= pos_wrap;
        end
    end

    // Clearing pointer and window read index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            rd_idx_reg  <= '0;
            acc_en_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (cmd.clr_acc)
            begin
                rd_idx_reg <= '0;
            end
            else if (cmd.rd_issue)
            begin
                rd_idx_reg <= rd_idx_reg + MAX_WINDOW_LOG2'(1);
            end
            acc_en_reg <= cmd.rd_issue;
        end
    end

    // Single write port, single registered read port
    assign mem_we  = cmd.clear_step | cmd.write;
    assign mem_wa  = cmd.clear_step ? clr_cnt_reg : {ch_idx, pos_cur};
    assign mem_wd  = cmd.clear_step ? '0 : sample_reg;
    assign rd_addr = {ch_idx, rd_idx_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Accumulate one entry per cycle, in the cycle after its read
    always_ff @(posedge clk)
    begin
        if (cmd.clr_acc)
        begin
            acc_reg <= '0;
        end
        else if (acc_en_reg)
        begin
            acc_reg <= acc_reg + SUM_W'(rd_data_reg);
        end
    end

    // Truncating mean, or the raw sample on bypass
    assign shifted    = acc_reg >> size_reg;
    assign result_val = bypass_reg ? sample_reg : shifted[SAMPLE_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            average_reg <= result_val;
        end
    end

    assign average           = average_reg;
    assign status.clear_last = (clr_cnt_reg == ADDR_W'(MEM_DEPTH - 1));
    assign status.rd_last    = (rd_idx_reg == win_last[MAX_WINDOW_LOG2-1:0]);
    assign status.bypass     = bypass_reg;

endmodule

[rtl/mma_ctrl.sv]
// Controller: memory clearing, per-transaction sequencing and output valid.
`timescale 1ns / 1ps
module mma_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    output logic                 result_valid,
    input  logic                 result_stall,
    input  mma_pkg::mma_status_t status,
    output mma_pkg::mma_cmd_t    cmd
);
    import mma_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.clr_acc = 1'b1;
                cmd.write   = !status.bypass;
                state_next  = status.bypass ? ST_DONE : ST_READ;
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                if (status.rd_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on load, held while stalled
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && result_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;

endmodule

[rtl/multichannel_moving_average_core.sv]
// Input is accepted only in the idle state; each transaction is captured and, unless
// bypassed, written and its window summed one entry per cycle through the single memory
// read port; the output register loads the result once the previous one is taken.
// Reset: asynchronous, active low; afterwards the sample memory is cleared one entry a
// cycle, all CHANNELS * 2^MAX_WINDOW_LOG2 entries (256 by default), with input stalled.
`timescale 1ns / 1ps
module multichannel_moving_average_core #(
    parameter int CHANNELS        = mma_pkg::CHANNELS_DEF,
    parameter int MAX_WINDOW_LOG2 = mma_pkg::MAX_WINDOW_LOG2_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [mma_pkg::CHAN_W-1:0]    channel,
    input  logic [mma_pkg::SAMPLE_W-1:0]  sample,
    input  logic [mma_pkg::WIN_W-1:0]     window_log2,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [mma_pkg::SAMPLE_W-1:0]  average
);
    import mma_pkg::*;

    mma_cmd_t    cmd;
    mma_status_t status;

    // Sequencer
    mma_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    // Storage and arithmetic
    mma_datapath #(
        .CHANNELS        (CHANNELS),
        .MAX_WINDOW_LOG2 (MAX_WINDOW_LOG2)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .channel     (channel),
        .sample      (sample),
        .window_log2 (window_log2),
        .cmd         (cmd),
        .status      (status),
        .average     (average)
    );

endmodule

[rtl/mma_checker.sv]
// Port-level checker for the moving average core, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mma_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_valid,
    input logic                          item_stall,
    input logic                          result_valid,
    input logic                          result_stall,
    input logic [mma_pkg::SAMPLE_W-1:0]  average
);
    import mma_pkg::*;

    logic item_accept;
    assign item_accept = item_valid && !item_stall;

    // A pending result is not dropped
    `MMA_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid)
    // A pending result does not change
    `MMA_ASSERT_NEXT(a_average_held, result_valid && result_stall, $stable(average))
    // One transaction at a time: busy right after an accept
    `MMA_ASSERT_NEXT(a_busy_after_accept, item_accept, item_stall)
    // No result can appear on the cycle after an accept
    `MMA_ASSERT_SAME(a_no_instant_result, $past(item_accept) && $past(rst_n), !$rose(result_valid))

endmodule

bind multichannel_moving_average_core mma_checker u_mma_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .average      (average)
);

[test/tb_multichannel_moving_average_core.sv]
// Self-checking testbench for the multichannel moving average core.
`timescale 1ns / 1ps
module tb_multichannel_moving_average_core;

    import mma_pkg::*;

    localparam int NUM_CHAN   = CHANNELS_DEF;
    localparam int WIN_MAX    = MAX_WINDOW_LOG2_DEF;
    localparam int WIN_DEPTH  = 1 << WIN_MAX;
    localparam int HOLD_LEN   = 600;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_WAIT = 80;

    typedef struct {
        logic [CHAN_W-1:0]   chan;
        logic [SAMPLE_W-1:0] smp;
        logic [WIN_W-1:0]    wlog;
    } sample_txn_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_stall;
    logic [CHAN_W-1:0]   channel      = '0;
    logic [SAMPLE_W-1:0] sample       = '0;
    logic [WIN_W-1:0]    window_log2  = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [SAMPLE_W-1:0] average;

    // Stimulus and scoreboard state
    sample_txn_t         txn_queue[$];
    logic [SAMPLE_W-1:0] expected_avg[$];
    logic [SAMPLE_W-1:0] chan_history[NUM_CHAN][WIN_DEPTH] = '{default: '0};
    int unsigned         chan_wr_ptr[NUM_CHAN] = '{default: 0};
    logic                txn_taken     = 1'b0;
    int unsigned         send_idle_pct = 0;
    int unsigned         recv_stall_pct = 0;
    logic                hold_request  = 1'b0;
    logic                hold_served   = 1'b0;
    int unsigned         hold_left     = 0;
    int unsigned         idle_cycles   = 0;
    int unsigned         mismatch_count = 0;

    multichannel_moving_average_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .channel      (channel),
        .sample       (sample),
        .window_log2  (window_log2),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .average      (average)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Store the sample, advance the channel pointer, return the truncated window mean
    function automatic logic [SAMPLE_W-1:0] window_mean(input logic [CHAN_W-1:0] ch,
                                                         input logic [SAMPLE_W-1:0] smp,
                                                         input logic [WIN_W-1:0] wlog);
        int unsigned size;
        int unsigned len;
        int unsigned pos;
        logic [31:0] sum;
        if (wlog == 0 || ch >= NUM_CHAN)
            return smp;
        size = (wlog > WIN_MAX) ? WIN_MAX : wlog;
        len  = 1 << size;
        pos  = chan_wr_ptr[ch] & (WIN_DEPTH - 1);
        chan_history[ch][pos] = smp;
        pos = pos + 1;
        if (pos >= len)
            pos = 0;
        chan_wr_ptr[ch] = pos;
        sum = '0;
        for (int i = 0; i < len; i++)
            sum += chan_history[ch][i];
        return SAMPLE_W'(sum >> size);
    endfunction

    task automatic push_txn(input int ch, input int smp, input int wlog);
        sample_txn_t t;
        t.chan = CHAN_W'(ch);
        t.smp  = SAMPLE_W'(smp);
        t.wlog = WIN_W'(wlog);
        txn_queue.push_back(t);
    endtask

    // Mostly bursts on one channel with a fixed window, some loose noise in between
    task automatic push_random(input int count);
        int pushed;
        int ch;
        int wlog;
        int eff;
        int len;
        int mode;
        int smp;
        pushed = 0;
        while (pushed < count)
        begin
            if ($urandom_range(9) < 7)
            begin
                ch   = $urandom_range(NUM_CHAN - 1);
                wlog = $urandom_range(7, 1);
                eff  = (wlog > WIN_MAX) ? WIN_MAX : wlog;
                len  = $urandom_range((1 << eff) + 4, 1);
                mode = $urandom_range(3);
                for (int i = 0; i < len && pushed < count; i++)
                begin
                    case (mode)
                        0: smp = $urandom_range(65535);
                        1: smp = 16'hFFFF;
                        2: smp = 0;
                        default: smp = $urandom_range(65535, 65000);
                    endcase
                    push_txn(ch, smp, wlog);
                    pushed++;
                end
            end
            else
            begin
                push_txn($urandom_range(NUM_CHAN - 1), $urandom_range(65535),
                         $urandom_range(7));
                pushed++;
            end
        end
    endtask

    task automatic wait_sent();
        while (txn_queue.size() != 0 || item_valid)
            @(posedge clk);
    endtask

    // Driver: offers queued transactions at the falling edge
    always @(negedge clk)
    begin : drive_proc
        sample_txn_t nxt;
        if (rst_n && (!item_valid || txn_taken))
        begin
            if (txn_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = txn_queue.pop_front();
                item_valid  <= 1'b1;
                channel     <= nxt.chan;
                sample      <= nxt.smp;
                window_log2 <= nxt.wlog;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (hold_request && !hold_served)
        begin
            hold_served = 1'b1;
            hold_left   = HOLD_LEN - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor: predict on input transactions, check on output transactions
    always @(posedge clk)
    begin
        txn_taken <= item_valid && !item_stall;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                expected_avg.push_back(window_mean(channel, sample, window_log2));
            if (result_valid && !result_stall)
            begin
                if (expected_avg.size() == 0)
                begin
                    $error("average: unexpected result %0d", average);
                    mismatch_count++;
                end
                else
                begin
                    if (average !== expected_avg[0])
                    begin
                        $error("average: expected %0d, actual %0d", expected_avg[0], average);
                        mismatch_count++;
                    end
                    void'(expected_avg.pop_front());
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: bypass, saturation, each window size, stale pointer, bit patterns
        push_txn(0, 16'h0000, 0);
        push_txn(0, 16'hFFFF, 0);
        push_txn(0, 16'hFFFF, 1);
        push_txn(0, 16'hFFFF, 1);
        push_txn(0, 16'hFFFF, 1);
        push_txn(1, 16'hAAAA, 7);
        for (int i = 0; i < 4; i++)
            push_txn(1, 16'h5555, 6);
        push_txn(1, 16'h1234, 1);
        push_txn(1, 16'hFFFF, 1);
        push_txn(2, 16'h5555, 2);
        push_txn(2, 16'hAAAA, 2);
        push_txn(2, 16'hFFFF, 3);
        push_txn(2, 16'h0001, 4);
        push_txn(2, 16'h8000, 5);
        push_txn(3, 16'hFFFF, 6);
        push_txn(3, 16'h7FFF, 3);
        push_txn(3, 16'hAAAA, 4);
        push_txn(3, 16'h5555, 0);
        push_txn(0, 16'h0000, 7);
        wait_sent();

        // Sender idle most of the time
        send_idle_pct  = 75;
        recv_stall_pct = 0;
        push_random(180);
        wait_sent();

        // Receiver stalling most of the time
        send_idle_pct  = 0;
        recv_stall_pct = 75;
        push_random(180);
        wait_sent();

        // Both sides idling
        send_idle_pct  = 30;
        recv_stall_pct = 30;
        push_random(180);
        wait_sent();

        // No idling, then a long receiver hold-off while input keeps coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        push_random(120);
        wait_sent();
        hold_request = 1'b1;
        push_random(80);
        wait_sent();

        while (expected_avg.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/mma_pkg.sv
rtl/mma_datapath.sv
rtl/mma_ctrl.sv
rtl/multichannel_moving_average_core.sv
rtl/mma_checker.sv
test/tb_multichannel_moving_average_core.sv
